// File: rtl/ubxfr_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the ubx frame receiver
package ubxfr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 16;
  localparam int unsigned EventW = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [ByteW-1:0] SyncFirstReset  = 8'hB5;
  localparam logic [ByteW-1:0] SyncSecondReset = 8'h62;
  localparam logic [LenW-1:0]  MaxLenReset     = 16'd1024;

  typedef enum logic [EventW-1:0] {
    EvNone     = 2'd0,
    EvOk       = 2'd1,
    EvChecksum = 2'd2,
    EvLength   = 2'd3
  } ev_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSyncFirst  = 2'd0,
    CfgSyncSecond = 2'd1,
    CfgMaxLen     = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [ByteW-1:0] sync_first;
    logic [ByteW-1:0] sync_second;
    logic [LenW-1:0]  max_payload_length;
  } cfg_t;

  typedef struct packed {
    ev_e              frame_event;
    logic [ByteW-1:0] msg_class;
    logic [ByteW-1:0] msg_ident;
    logic [LenW-1:0]  payload_length;
    logic [ByteW-1:0] payload_byte;
    logic             payload_valid;
    logic [LenW-1:0]  payload_index;
  } result_t;

endpackage

// File: rtl/ubxfr_if.sv
`timescale 1ns / 1ps
// handshake channel interfaces: received bytes, results, register writes
interface ubxfr_byte_if
  import ubxfr_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ubxfr_result_if
  import ubxfr_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [EventW-1:0] frame_event;
  logic [ByteW-1:0]  msg_class;
  logic [ByteW-1:0]  msg_ident;
  logic [LenW-1:0]   payload_length;
  logic [ByteW-1:0]  payload_byte;
  logic              payload_valid;
  logic [LenW-1:0]   payload_index;

  modport source (output valid, output frame_event, output msg_class, output msg_ident,
                  output payload_length, output payload_byte, output payload_valid,
                  output payload_index, input ready);
  modport sink   (input valid, input frame_event, input msg_class, input msg_ident,
                  input payload_length, input payload_byte, input payload_valid,
                  input payload_index, output ready);
endinterface

interface ubxfr_cfg_if
  import ubxfr_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/ubxfr_parser.sv
`timescale 1ns / 1ps
// frame parse state machine with fletcher checksum, one byte per request
module ubxfr_parser
  import ubxfr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [ByteW-1:0] rx_byte_i,
  input  cfg_t             cfg_i,
  output result_t          res_o
);

  localparam logic [2:0] PhSync1   = 3'd0;
  localparam logic [2:0] PhSync2   = 3'd1;
  localparam logic [2:0] PhClass   = 3'd2;
  localparam logic [2:0] PhIdent   = 3'd3;
  localparam logic [2:0] PhLength  = 3'd4;
  localparam logic [2:0] PhPayload = 3'd5;
  localparam logic [2:0] PhCheck1  = 3'd6;
  localparam logic [2:0] PhCheck2  = 3'd7;

  logic [2:0]       phase_q, phase_d;
  logic [ByteW-1:0] class_q, class_d;
  logic [ByteW-1:0] ident_q, ident_d;
  logic [LenW-1:0]  length_q, length_d;
  logic [LenW-1:0]  seen_q, seen_d;
  logic [ByteW-1:0] sum_a_q, sum_a_d;
  logic [ByteW-1:0] sum_b_q, sum_b_d;
  logic [ByteW-1:0] chk1_q, chk1_d;

  logic [ByteW-1:0] sum_a_add, sum_b_add;
  logic [LenW-1:0]  seen_inc, len_full;

  assign sum_a_add = sum_a_q + rx_byte_i;
  assign sum_b_add = sum_b_q + sum_a_add;
  assign seen_inc  = seen_q + 16'd1;
  assign len_full  = {rx_byte_i, length_q[7:0]};

  always_comb begin
    phase_d  = phase_q;
    class_d  = class_q;
    ident_d  = ident_q;
    length_d = length_q;
    seen_d   = seen_q;
    sum_a_d  = sum_a_q;
    sum_b_d  = sum_b_q;
    chk1_d   = chk1_q;
    res_o.frame_event   = EvNone;
    res_o.payload_byte  = '0;
    res_o.payload_valid = 1'b0;
    res_o.payload_index = '0;
    unique case (phase_q)
      PhSync1: begin
        if (rx_byte_i == cfg_i.sync_first) phase_d = PhSync2;
      end
      PhSync2: begin
        if (rx_byte_i == cfg_i.sync_second) begin
          phase_d = PhClass;
          sum_a_d = '0;
          sum_b_d = '0;
          seen_d  = '0;
        end else begin
          phase_d = PhSync1;
        end
      end
      PhClass: begin
        class_d = rx_byte_i;
        sum_a_d = sum_a_add;
        sum_b_d = sum_b_add;
        phase_d = PhIdent;
      end
      PhIdent: begin
        ident_d = rx_byte_i;
        sum_a_d = sum_a_add;
        sum_b_d = sum_b_add;
        phase_d = PhLength;
        seen_d  = '0;
      end
      PhLength: begin
        sum_a_d = sum_a_add;
        sum_b_d = sum_b_add;
        if (seen_q == '0) begin
          length_d = {8'd0, rx_byte_i};
          seen_d   = 16'd1;
        end else begin
          length_d = len_full;
          seen_d   = '0;
          if (len_full > cfg_i.max_payload_length) begin
            res_o.frame_event = EvLength;
            phase_d = PhSync1;
          end else if (len_full == '0) begin
            phase_d = PhCheck1;
          end else begin
            phase_d = PhPayload;
          end
        end
      end
      PhPayload: begin
        sum_a_d = sum_a_add;
        sum_b_d = sum_b_add;
        res_o.payload_byte  = rx_byte_i;
        res_o.payload_valid = 1'b1;
        res_o.payload_index = seen_q;
        seen_d = seen_inc;
        if (seen_inc >= length_q) phase_d = PhCheck1;
      end
      PhCheck1: begin
        chk1_d  = rx_byte_i;
        phase_d = PhCheck2;
      end
      PhCheck2: begin
        res_o.frame_event = (sum_a_q == chk1_q && sum_b_q == rx_byte_i) ? EvOk : EvChecksum;
        phase_d = PhSync1;
      end
    endcase
    res_o.msg_class      = class_d;
    res_o.msg_ident      = ident_d;
    res_o.payload_length = length_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhSync1;
      class_q  <= '0;
      ident_q  <= '0;
      length_q <= '0;
      seen_q   <= '0;
      sum_a_q  <= '0;
      sum_b_q  <= '0;
      chk1_q   <= '0;
    end else if (fire_i) begin
      phase_q  <= phase_d;
      class_q  <= class_d;
      ident_q  <= ident_d;
      length_q <= length_d;
      seen_q   <= seen_d;
      sum_a_q  <= sum_a_d;
      sum_b_q  <= sum_b_d;
      chk1_q   <= chk1_d;
    end
  end

endmodule

// File: rtl/ubxfr_out_stage.sv
`timescale 1ns / 1ps
// result register with skid entry that takes one more input under back-pressure
module ubxfr_out_stage
  import ubxfr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  result_t in_data_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_data_o
);

  result_t out_q, skid_q;
  logic    out_valid_q, skid_valid_q;
  logic    in_fire, out_free;

  assign in_ready_o  = !skid_valid_q;
  assign in_fire     = in_valid_i && !skid_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || in_fire;
      skid_valid_q <= 1'b0;
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : in_data_i;
    end else if (in_fire) begin
      skid_q <= in_data_i;
    end
  end

endmodule

// File: rtl/ubx_frame_receiver.sv
`timescale 1ns / 1ps
// top level of the ubx frame receiver: config registers, parser, result stage
// an accepted byte's result is registered; it waits in the skid entry under a stall
// throughput: one byte per cycle while the skid entry is empty
// a two-entry result stage (register plus skid) keeps rx ready until the skid fills
// reset: async active low; parser back to sync hunt, holds and sums cleared,
//   sync bytes 0xb5/0x62 and max payload 1024 restored, no result pending
module ubx_frame_receiver
  import ubxfr_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  ubxfr_byte_if.sink     rx_i,
  ubxfr_result_if.source res_o,
  ubxfr_cfg_if.sink      cfg_i
);

  cfg_t    cfg_q;
  result_t parse_res, out_res;
  logic    rx_ready, rx_fire;

  // register writes are always taken; unknown index is dropped
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first         <= SyncFirstReset;
      cfg_q.sync_second        <= SyncSecondReset;
      cfg_q.max_payload_length <= MaxLenReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgSyncFirst:  cfg_q.sync_first         <= cfg_i.data[ByteW-1:0];
        CfgSyncSecond: cfg_q.sync_second        <= cfg_i.data[ByteW-1:0];
        CfgMaxLen:     cfg_q.max_payload_length <= cfg_i.data[LenW-1:0];
        default: ;
      endcase
    end
  end

  // a byte request moves the parser state and enters the result stage together
  assign rx_i.ready = rx_ready;
  assign rx_fire    = rx_i.valid && rx_ready;

  ubxfr_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (rx_fire),
    .rx_byte_i (rx_i.rx_byte),
    .cfg_i     (cfg_q),
    .res_o     (parse_res)
  );

  ubxfr_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rx_i.valid),
    .in_ready_o  (rx_ready),
    .in_data_i   (parse_res),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .out_data_o  (out_res)
  );

  // unpack the registered result onto the channel
  assign res_o.frame_event    = out_res.frame_event;
  assign res_o.msg_class      = out_res.msg_class;
  assign res_o.msg_ident      = out_res.msg_ident;
  assign res_o.payload_length = out_res.payload_length;
  assign res_o.payload_byte   = out_res.payload_byte;
  assign res_o.payload_valid  = out_res.payload_valid;
  assign res_o.payload_index  = out_res.payload_index;

endmodule

// File: rtl/ubxfr_checker.sv
`timescale 1ns / 1ps
// port-level checker for the ubx frame receiver, bound to the top level
module ubxfr_checker
  import ubxfr_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              rx_valid_i,
  input logic              rx_ready_i,
  input logic              res_valid_i,
  input logic              res_ready_i,
  input logic [EventW-1:0] frame_event_i,
  input logic [ByteW-1:0]  payload_byte_i,
  input logic              payload_valid_i,
  input logic [LenW-1:0]   payload_index_i,
  input logic              cfg_ready_i
);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result dropped while stalled");

  a_rx_to_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_valid_i && rx_ready_i |=> res_valid_i)
    else $error("accepted byte produced no result");

  a_payload_no_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && payload_valid_i |-> frame_event_i == EvNone)
    else $error("payload byte carries a frame event");

  a_idle_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !payload_valid_i |-> payload_byte_i == '0 && payload_index_i == '0)
    else $error("payload fields set on non-payload byte");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i)
    else $error("config channel not ready");

endmodule

bind ubx_frame_receiver ubxfr_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .rx_valid_i      (rx_i.valid),
  .rx_ready_i      (rx_i.ready),
  .res_valid_i     (res_o.valid),
  .res_ready_i     (res_o.ready),
  .frame_event_i   (res_o.frame_event),
  .payload_byte_i  (res_o.payload_byte),
  .payload_valid_i (res_o.payload_valid),
  .payload_index_i (res_o.payload_index),
  .cfg_ready_i     (cfg_i.ready)
);

// File: sim/tb_ubx_frame_receiver.sv
`timescale 1ns / 1ps
// self-checking testbench for the ubx frame receiver: framed byte traffic against a predictor

import ubxfr_pkg::*;

// byte-level frame predictor plus the queue of results still owed by the block
class frame_scoreboard;

  typedef enum logic [2:0] {
    HuntFirst, HuntSecond, TakeClass, TakeIdent,
    TakeLength, TakePayload, TakeCheckA, TakeCheckB
  } parse_step_e;

  // register copies
  logic [ByteW-1:0] sync_a;
  logic [ByteW-1:0] sync_b;
  logic [LenW-1:0]  len_limit;

  // parser copy
  parse_step_e      step;
  logic [ByteW-1:0] cls;
  logic [ByteW-1:0] ident;
  logic [LenW-1:0]  len;
  logic [LenW-1:0]  count;
  logic [ByteW-1:0] sum_a;
  logic [ByteW-1:0] sum_b;
  logic [ByteW-1:0] chk_a;

  result_t          pending[$];
  int unsigned      mismatches;

  function new();
    sync_a     = SyncFirstReset;
    sync_b     = SyncSecondReset;
    len_limit  = MaxLenReset;
    step       = HuntFirst;
    cls        = '0;
    ident      = '0;
    len        = '0;
    count      = '0;
    sum_a      = '0;
    sum_b      = '0;
    chk_a      = '0;
    mismatches = 0;
  endfunction

  function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    case (idx)
      CfgSyncFirst:  sync_a = data[ByteW-1:0];
      CfgSyncSecond: sync_b = data[ByteW-1:0];
      CfgMaxLen:     len_limit = data[LenW-1:0];
      default: ;
    endcase
  endfunction

  function void add_sum(logic [ByteW-1:0] b);
    sum_a = sum_a + b;
    sum_b = sum_b + sum_a;
  endfunction

  // one received byte, one expected result
  function void note_byte(logic [ByteW-1:0] b);
    result_t want;
    want = '0;
    want.frame_event = EvNone;
    case (step)
      HuntFirst: if (b == sync_a) step = HuntSecond;
      HuntSecond: begin
        if (b == sync_b) begin
          step  = TakeClass;
          sum_a = '0;
          sum_b = '0;
          count = '0;
        end else begin
          step = HuntFirst;
        end
      end
      TakeClass: begin
        cls = b;
        add_sum(b);
        step = TakeIdent;
      end
      TakeIdent: begin
        ident = b;
        add_sum(b);
        step  = TakeLength;
        count = '0;
      end
      TakeLength: begin
        add_sum(b);
        if (count == 0) begin
          len   = {8'h00, b};
          count = 16'd1;
        end else begin
          len   = {b, len[7:0]};
          count = '0;
          if (len > len_limit) begin
            want.frame_event = EvLength;
            step = HuntFirst;
          end else if (len == 0) begin
            step = TakeCheckA;
          end else begin
            step = TakePayload;
          end
        end
      end
      TakePayload: begin
        add_sum(b);
        want.payload_byte  = b;
        want.payload_valid = 1'b1;
        want.payload_index = count;
        count = count + 16'd1;
        if (count >= len) step = TakeCheckA;
      end
      TakeCheckA: begin
        chk_a = b;
        step  = TakeCheckB;
      end
      default: begin
        want.frame_event = (sum_a == chk_a && sum_b == b) ? EvOk : EvChecksum;
        step = HuntFirst;
      end
    endcase
    want.msg_class      = cls;
    want.msg_ident      = ident;
    want.payload_length = len;
    pending.push_back(want);
  endfunction

  task report(string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  task check_result(result_t got);
    result_t want;
    if (pending.size() == 0) begin
      report("result with nothing expected");
      return;
    end
    want = pending.pop_front();
    if (got.frame_event !== want.frame_event)
      report($sformatf("frame_event %0d, want %0d", got.frame_event, want.frame_event));
    if (got.msg_class !== want.msg_class)
      report($sformatf("msg_class %0h, want %0h", got.msg_class, want.msg_class));
    if (got.msg_ident !== want.msg_ident)
      report($sformatf("msg_ident %0h, want %0h", got.msg_ident, want.msg_ident));
    if (got.payload_length !== want.payload_length)
      report($sformatf("payload_length %0d, want %0d", got.payload_length,
                       want.payload_length));
    if (got.payload_byte !== want.payload_byte)
      report($sformatf("payload_byte %0h, want %0h", got.payload_byte, want.payload_byte));
    if (got.payload_valid !== want.payload_valid)
      report($sformatf("payload_valid %0b, want %0b", got.payload_valid,
                       want.payload_valid));
    if (got.payload_index !== want.payload_index)
      report($sformatf("payload_index %0d, want %0d", got.payload_index,
                       want.payload_index));
  endtask

endclass

module tb_ubx_frame_receiver;

  // index past the last register, the block must ignore writes to it
  localparam logic [CfgIdxW-1:0] CfgNoReg = 2'd3;
  // receiver hold-off, long enough to fill the result stage and stall rx
  localparam int unsigned HoldOffCycles = 300;
  // cycles with no request moving on any channel before giving up
  localparam int unsigned WatchdogLimit = 3000;

  logic clk_i = 1'b0;
  logic rst_ni;

  ubxfr_byte_if   rx_bus ();
  ubxfr_result_if res_bus ();
  ubxfr_cfg_if    cfg_bus ();

  ubx_frame_receiver u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_bus),
    .res_o  (res_bus),
    .cfg_i  (cfg_bus)
  );

  frame_scoreboard sb;

  int unsigned sent;         // rx requests accepted so far
  bit          no_idle;      // both sides run flat out while set
  bit          hold_off_req; // asks the receiver for one long hold-off
  int unsigned quiet_cycles;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // monitors: sample every channel at the edge where a request moves
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni) begin
      if (cfg_bus.valid && cfg_bus.ready) sb.write_reg(cfg_bus.index, cfg_bus.data);
      if (rx_bus.valid && rx_bus.ready) sb.note_byte(rx_bus.rx_byte);
      if (res_bus.valid && res_bus.ready) begin
        got.frame_event    = ev_e'(res_bus.frame_event);
        got.msg_class      = res_bus.msg_class;
        got.msg_ident      = res_bus.msg_ident;
        got.payload_length = res_bus.payload_length;
        got.payload_byte   = res_bus.payload_byte;
        got.payload_valid  = res_bus.payload_valid;
        got.payload_index  = res_bus.payload_index;
        sb.check_result(got);
      end
    end
  end

  // watchdog: any request on any channel counts as progress
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((rx_bus.valid && rx_bus.ready) || (res_bus.valid && res_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("tb_ubx_frame_receiver: FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // result side: random stalls, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    res_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        res_bus.ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end
      res_bus.ready <= no_idle || ($urandom_range(99) >= 12);
    end
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------

  // offer one byte, with a random gap in front, and wait until it is taken
  task automatic send_byte(input logic [ByteW-1:0] b);
    while (!no_idle && $urandom_range(99) < 12) begin
      rx_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    rx_bus.valid   <= 1'b1;
    rx_bus.rx_byte <= b;
    do @(posedge clk_i); while (!rx_bus.ready);
    sent++;
  endtask

  // register write; valid drops between requests
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // stop offering and let every owed result drain, then idle before returning
  task automatic quiesce();
    rx_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // full frame with the current sync bytes; an over-limit length stops after
  // the header since the block drops the frame there
  task automatic send_frame(input logic [ByteW-1:0] cls, input logic [ByteW-1:0] ident,
                            input logic [LenW-1:0] len, input bit bad_check);
    logic [ByteW-1:0] fa, fb, pb;
    logic [31:0]      hdr;
    int unsigned      k;
    fa  = '0;
    fb  = '0;
    hdr = {cls, ident, len[7:0], len[15:8]};
    send_byte(sb.sync_a);
    send_byte(sb.sync_b);
    for (k = 0; k < 4; k++) begin
      pb = hdr[31 - 8*k -: 8];
      send_byte(pb);
      fa = fa + pb;
      fb = fb + fa;
    end
    if (len > sb.len_limit) return;
    for (k = 0; k < len; k++) begin
      pb = 8'($urandom_range(255));
      send_byte(pb);
      fa = fa + pb;
      fb = fb + fa;
    end
    // flip a single bit in one of the two check bytes
    if (bad_check) begin
      if ($urandom_range(1) == 0) fa = fa ^ 8'(1 << $urandom_range(7));
      else fb = fb ^ 8'(1 << $urandom_range(7));
    end
    send_byte(fa);
    send_byte(fb);
  endtask

  // mostly well-formed frames with random content, plus broken syncs and noise
  task automatic random_traffic(input int unsigned n_bytes);
    int unsigned      stop_at, pick;
    logic [LenW-1:0]  cap, len;
    logic [ByteW-1:0] b;
    stop_at = sent + n_bytes;
    while (sent < stop_at) begin
      pick = $urandom_range(99);
      cap  = (sb.len_limit < 16) ? sb.len_limit : 16'd16;
      len  = 16'($urandom_range(cap, 0));
      // payload exactly at the limit
      if (sb.len_limit <= 64 && $urandom_range(9) == 0) len = sb.len_limit;
      if (pick < 62) begin
        send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), len,
                   $urandom_range(99) < 15);
      end else if (pick < 72 && sb.len_limit != 16'hFFFF) begin
        // declared length over the limit, often just one past it
        if ($urandom_range(1) == 0) len = sb.len_limit + 16'd1;
        else len = 16'($urandom_range(16'hFFFF, sb.len_limit + 1));
        send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), len, 1'b0);
      end else if (pick < 80) begin
        // first sync byte followed by a wrong second one
        send_byte(sb.sync_a);
        b = 8'($urandom_range(255));
        if (b == sb.sync_b) b = ~b;
        send_byte(b);
      end else if (pick < 88) begin
        // repeated first sync byte is not taken as a new start
        send_byte(sb.sync_a);
        send_byte(sb.sync_a);
        send_byte(sb.sync_b);
      end else begin
        repeat ($urandom_range(5, 1)) send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    sb             = new();
    sent           = 0;
    no_idle        = 1'b0;
    hold_off_req   = 1'b0;
    quiet_cycles   = 0;
    rst_ni         = 1'b0;
    rx_bus.valid   = 1'b0;
    rx_bus.rx_byte = '0;
    cfg_bus.valid  = 1'b0;
    cfg_bus.index  = CfgSyncFirst;
    cfg_bus.data   = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset register values
    // bad second sync byte; it must not be taken as a new first sync byte
    send_byte(sb.sync_a);
    send_byte(sb.sync_a);
    send_byte(sb.sync_b);
    // zero-length frame, class and id at opposite extremes
    send_frame(8'hFF, 8'h00, 16'd0, 1'b0);
    // one-byte payload with a checksum error
    send_frame(8'h00, 8'hFF, 16'd1, 1'b1);
    // largest declared length, over the limit
    send_frame(8'h5A, 8'hA5, 16'hFFFF, 1'b0);
    quiesce();

    // sync bytes 0x00/0xff, only zero-length payloads fit; upper data bits
    // of the byte registers are masked off, index past the end is ignored
    write_reg(CfgSyncFirst, 16'hFF00);
    write_reg(CfgSyncSecond, 16'h00FF);
    write_reg(CfgMaxLen, 16'h0000);
    write_reg(CfgNoReg, 16'hFFFF);
    random_traffic(200);
    quiesce();

    // opposite sync extremes, no length limit
    write_reg(CfgSyncFirst, 16'h00FF);
    write_reg(CfgSyncSecond, 16'hFF00);
    write_reg(CfgMaxLen, 16'hFFFF);
    random_traffic(250);
    quiesce();

    // standard sync bytes and a small limit so the boundary is hit often
    write_reg(CfgSyncFirst, 16'h12B5);
    write_reg(CfgSyncSecond, 16'h3462);
    write_reg(CfgMaxLen, 16'($urandom_range(12, 3)));
    no_idle = 1'b1;
    random_traffic(150);
    no_idle = 1'b0;
    random_traffic(100);
    // receiver holds off while the sender keeps offering bytes
    hold_off_req = 1'b1;
    random_traffic(200);

    // drain and give late or extra results a chance to show up
    quiesce();
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("tb_ubx_frame_receiver: PASS");
    end else begin
      $display("tb_ubx_frame_receiver: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/ubxfr_pkg.sv
rtl/ubxfr_if.sv
rtl/ubxfr_parser.sv
rtl/ubxfr_out_stage.sv
rtl/ubx_frame_receiver.sv
rtl/ubxfr_checker.sv
sim/tb_ubx_frame_receiver.sv
